FILE: rtl/fpm_pkg.sv
package fpm_pkg;

    // Sample and statistic width in bits; values are in microseconds.
    localparam int SAMPLE_W = 24;

    localparam logic [23:0] CLAMP_MAX_US = 24'd10000000;
    localparam logic [23:0] SPIKE_A_US   = 24'd25000;
    localparam logic [23:0] SPIKE_B_US   = 24'd33333;
    localparam logic [23:0] SPIKE_C_US   = 24'd50000;
    localparam logic [31:0] WARMUP_FRAMES = 32'd8;
    localparam logic [3:0]  PERIOD_LAST   = 4'd14;

    // Opcodes of the input item.
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_END   = 1'b1;

    // Percentile weights and rounding term.
    localparam logic [6:0] K_P50 = 7'd50;
    localparam logic [6:0] K_P95 = 7'd95;
    localparam logic [6:0] K_P99 = 7'd99;
    localparam logic [6:0] ROUND_HALF = 7'd50;

    // Reciprocal of 100 in 24 fractional bits, exact for numerators below 2^17.
    localparam logic [17:0] RECIP_100 = 18'd167773;
    localparam int          RECIP_SHIFT = 24;

    localparam logic [4:0] TOP_BIT = 5'd23;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_DIFF   = 11'b00000000010,
        ST_CLAMP  = 11'b00000000100,
        ST_UPDATE = 11'b00000001000,
        ST_SETUP1 = 11'b00000010000,
        ST_SETUP2 = 11'b00000100000,
        ST_SCAN   = 11'b00001000000,
        ST_BITEND = 11'b00010000000,
        ST_DIV    = 11'b00100000000,
        ST_FINISH = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic accept_begin;
        logic accept_end;
        logic diff;
        logic clamp;
        logic update;
        logic setup1;
        logic setup2;
        logic scan;
        logic bitend;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic refresh_due;
        logic scan_last;
        logic bit_zero;
        logic div_last;
    } sts_t;

endpackage

FILE: rtl/fpm_if.sv
interface fpm_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] timestamp_us;

    modport source (output valid, output opcode, output timestamp_us, input ready);
    modport sink (input valid, input opcode, input timestamp_us, output ready);
endinterface

interface fpm_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] last_us;
    logic [23:0] average_us;
    logic [23:0] median_us;
    logic [23:0] pct95_us;
    logic [23:0] pct99_us;
    logic [23:0] peak_us;
    logic [7:0]  window_fill;
    logic [31:0] frames_seen;
    logic [31:0] spikes_over_25;
    logic [31:0] spikes_over_33;
    logic [31:0] spikes_over_50;
    logic        stats_refreshed;

    modport source (
        output valid, output last_us, output average_us, output median_us,
        output pct95_us, output pct99_us, output peak_us, output window_fill,
        output frames_seen, output spikes_over_25, output spikes_over_33,
        output spikes_over_50, output stats_refreshed, input ready
    );
    modport sink (
        input valid, input last_us, input average_us, input median_us,
        input pct95_us, input pct99_us, input peak_us, input window_fill,
        input frames_seen, input spikes_over_25, input spikes_over_33,
        input spikes_over_50, input stats_refreshed, output ready
    );
endinterface

FILE: rtl/frame_time_percentile_monitor_core.sv
// A begin item only records its start time. An end item without refresh passes the diff,
// clamp and update states before its result; with refresh it adds rank setup, 24 bit-serial
// passes over the single ring read port, each over the n filled entries, and the mean division.
// One item is in work at a time; the next is taken after the result is delivered.
// Reset clears counters, start time and held statistics to zero; the ring is not cleared.
module frame_time_percentile_monitor_core #(
    parameter int WINDOW_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    fpm_in_if.sink     in_ch,
    fpm_out_if.source  out_ch
);

    fpm_pkg::cmd_t cmd;
    fpm_pkg::sts_t sts;
    logic          in_ready;
    logic          out_valid;

    // Sequencer.
    fpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Timing, window and statistics datapath.
    fpm_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .timestamp_us    (in_ch.timestamp_us),
        .last_us         (out_ch.last_us),
        .average_us      (out_ch.average_us),
        .median_us       (out_ch.median_us),
        .pct95_us        (out_ch.pct95_us),
        .pct99_us        (out_ch.pct99_us),
        .peak_us         (out_ch.peak_us),
        .window_fill     (out_ch.window_fill),
        .frames_seen     (out_ch.frames_seen),
        .spikes_over_25  (out_ch.spikes_over_25),
        .spikes_over_33  (out_ch.spikes_over_33),
        .spikes_over_50  (out_ch.spikes_over_50),
        .stats_refreshed (out_ch.stats_refreshed)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;

    // No item is taken while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input taken while result pending");

    // Early frames always refresh the statistics.
    a_warmup_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ch.frames_seen <= 32'd8) |-> out_ch.stats_refreshed)
        else $error("warm-up frame without refresh");

    // A delivered result always holds at least one sample.
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_ch.window_fill != 8'd0 || WINDOW_DEPTH >= 256))
        else $error("result with empty window");

endmodule

FILE: rtl/fpm_ctrl.sv
module fpm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_opcode,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  fpm_pkg::sts_t sts,
    output fpm_pkg::cmd_t cmd
);

    fpm_pkg::state_t state_reg;
    fpm_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands to the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            fpm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == fpm_pkg::OP_END)
                    begin
                        cmd.accept_end = 1'b1;
                        state_next     = fpm_pkg::ST_DIFF;
                    end
                    else
                    begin
                        cmd.accept_begin = 1'b1;
                    end
                end
            end
            fpm_pkg::ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = fpm_pkg::ST_CLAMP;
            end
            fpm_pkg::ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = fpm_pkg::ST_UPDATE;
            end
            fpm_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = sts.refresh_due ? fpm_pkg::ST_SETUP1 : fpm_pkg::ST_OUT;
            end
            fpm_pkg::ST_SETUP1:
            begin
                cmd.setup1 = 1'b1;
                state_next = fpm_pkg::ST_SETUP2;
            end
            fpm_pkg::ST_SETUP2:
            begin
                cmd.setup2 = 1'b1;
                state_next = fpm_pkg::ST_SCAN;
            end
            fpm_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = fpm_pkg::ST_BITEND;
                end
            end
            fpm_pkg::ST_BITEND:
            begin
                cmd.bitend = 1'b1;
                state_next = sts.bit_zero ? fpm_pkg::ST_DIV : fpm_pkg::ST_SCAN;
            end
            fpm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = fpm_pkg::ST_FINISH;
                end
            end
            fpm_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = fpm_pkg::ST_OUT;
            end
            fpm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = fpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/fpm_dp.sv
module fpm_dp #(
    parameter int WINDOW_DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fpm_pkg::cmd_t cmd,
    output fpm_pkg::sts_t sts,
    input  logic [63:0]   timestamp_us,
    output logic [23:0]   last_us,
    output logic [23:0]   average_us,
    output logic [23:0]   median_us,
    output logic [23:0]   pct95_us,
    output logic [23:0]   pct99_us,
    output logic [23:0]   peak_us,
    output logic [7:0]    window_fill,
    output logic [31:0]   frames_seen,
    output logic [31:0]   spikes_over_25,
    output logic [31:0]   spikes_over_33,
    output logic [31:0]   spikes_over_50,
    output logic          stats_refreshed
);

    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int SW   = fpm_pkg::SAMPLE_W + CW;
    localparam int DCW  = $clog2(SW);
    localparam int NUMW = CW + 7;
    localparam int PMW  = NUMW + 18;
    localparam int NR   = 4;

    // Sample ring.
    logic [23:0] ring_mem [WINDOW_DEPTH];

    logic [63:0]   start_reg;
    logic [63:0]   ts_reg;
    logic [64:0]   diff_reg;
    logic [23:0]   last_reg;
    logic [AW-1:0] slot_reg;
    logic [CW-1:0] fill_reg;
    logic [31:0]   frames_reg;
    logic [3:0]    mod_reg;
    logic [31:0]   spk_a_reg;
    logic [31:0]   spk_b_reg;
    logic [31:0]   spk_c_reg;
    logic          refreshed_reg;
    logic [23:0]   mean_reg;
    logic [23:0]   p50_reg;
    logic [23:0]   p95_reg;
    logic [23:0]   p99_reg;
    logic [23:0]   peak_reg;

    logic [NUMW-1:0] prod_reg [3];
    logic [CW-1:0]   rank_reg [NR];
    logic [CW-1:0]   cnt_reg  [NR];
    logic [23:0]     pfx_reg  [NR];
    logic [CW-1:0]   idx_reg;
    logic [4:0]      bit_reg;
    logic            rdv_reg;
    logic [23:0]     rd_reg;
    logic [SW-1:0]   sum_reg;
    logic [SW-1:0]   quo_reg;
    logic [CW:0]     rem_reg;
    logic [DCW-1:0]  dcnt_reg;

    logic [31:0]   frames_next;
    logic [3:0]    mod_next;
    logic [23:0]   elapsed;
    logic [23:0]   himask;
    logic [NR-1:0] match;
    logic [CW-1:0] n_minus1;
    logic [CW:0]   trial;
    logic [6:0]    kw [3];
    logic [PMW-1:0] pm [3];
    logic [CW:0]   q  [3];

    assign n_minus1 = fill_reg - CW'(1);
    assign kw[0] = fpm_pkg::K_P50;
    assign kw[1] = fpm_pkg::K_P95;
    assign kw[2] = fpm_pkg::K_P99;

    // Frame count and refresh rule; the mod-15 tracker restarts when the count wraps.
    always_comb
    begin
        frames_next = frames_reg + 32'd1;
        if (frames_next == 32'd0 || mod_reg == fpm_pkg::PERIOD_LAST)
        begin
            mod_next = 4'd0;
        end
        else
        begin
            mod_next = mod_reg + 4'd1;
        end
    end

    // Clamp of the elapsed time.
    always_comb
    begin
        if (diff_reg[64])
        begin
            elapsed = 24'd0;
        end
        else if (diff_reg[63:0] > 64'(fpm_pkg::CLAMP_MAX_US))
        begin
            elapsed = fpm_pkg::CLAMP_MAX_US;
        end
        else
        begin
            elapsed = diff_reg[23:0];
        end
    end

    // Bit-serial select: an entry counts when it shares the rank's prefix and has a zero here.
    assign himask = ~((24'd2 << bit_reg) - 24'd1);
    always_comb
    begin
        for (int k = 0; k < NR; k++)
        begin
            match[k] = (((rd_reg ^ pfx_reg[k]) & himask) == 24'd0) && !rd_reg[bit_reg];
        end
    end

    // Percentile index by reciprocal of 100.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pm[k] = PMW'(prod_reg[k]) * PMW'(fpm_pkg::RECIP_100);
            q[k]  = pm[k][PMW-1:fpm_pkg::RECIP_SHIFT];
        end
    end

    assign trial = {rem_reg[CW-1:0], quo_reg[SW-1]};

    assign sts.refresh_due = (frames_next <= fpm_pkg::WARMUP_FRAMES) || (mod_next == 4'd0);
    assign sts.scan_last   = (idx_reg == fill_reg);
    assign sts.bit_zero    = (bit_reg == 5'd0);
    assign sts.div_last    = (dcnt_reg == DCW'(0));

    // Ring write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ring_mem[slot_reg] <= last_reg;
        end
        if (cmd.scan && idx_reg < fill_reg)
        begin
            rd_reg <= ring_mem[idx_reg[AW-1:0]];
        end
    end

    // Event timing and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            last_reg      <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            frames_reg    <= '0;
            mod_reg       <= '0;
            spk_a_reg     <= '0;
            spk_b_reg     <= '0;
            spk_c_reg     <= '0;
            refreshed_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept_begin)
            begin
                start_reg <= timestamp_us;
            end
            if (cmd.clamp)
            begin
                last_reg <= elapsed;
            end
            if (cmd.update)
            begin
                slot_reg <= (slot_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + AW'(1);
                if (fill_reg < CW'(WINDOW_DEPTH))
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
                frames_reg    <= frames_next;
                mod_reg       <= mod_next;
                refreshed_reg <= sts.refresh_due;
                if (last_reg > fpm_pkg::SPIKE_A_US)
                begin
                    spk_a_reg <= spk_a_reg + 32'd1;
                end
                if (last_reg > fpm_pkg::SPIKE_B_US)
                begin
                    spk_b_reg <= spk_b_reg + 32'd1;
                end
                if (last_reg > fpm_pkg::SPIKE_C_US)
                begin
                    spk_c_reg <= spk_c_reg + 32'd1;
                end
            end
        end
    end

    // Held statistics.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            p50_reg  <= '0;
            p95_reg  <= '0;
            p99_reg  <= '0;
            peak_reg <= '0;
        end
        else if (cmd.finish)
        begin
            mean_reg <= quo_reg[23:0];
            p50_reg  <= pfx_reg[0];
            p95_reg  <= pfx_reg[1];
            p99_reg  <= pfx_reg[2];
            peak_reg <= pfx_reg[3];
        end
    end

    // Scan control flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg <= 1'b0;
        end
        else
        begin
            rdv_reg <= cmd.scan && (idx_reg < fill_reg);
        end
    end

    // End timestamp capture and difference, rank setup, window passes and mean division.
    always_ff @(posedge clk)
    begin
        if (cmd.accept_end)
        begin
            ts_reg <= timestamp_us;
        end
        if (cmd.diff)
        begin
            diff_reg <= {1'b0, ts_reg} - {1'b0, start_reg};
        end
        if (cmd.setup1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= NUMW'(n_minus1) * NUMW'(kw[k]) + NUMW'(fpm_pkg::ROUND_HALF);
            end
        end
        if (cmd.setup2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rank_reg[k] <= (q[k] < {1'b0, n_minus1}) ? q[k][CW-1:0] : n_minus1;
            end
            rank_reg[3] <= n_minus1;
            for (int k = 0; k < NR; k++)
            begin
                cnt_reg[k] <= '0;
                pfx_reg[k] <= '0;
            end
            idx_reg <= '0;
            bit_reg <= fpm_pkg::TOP_BIT;
            sum_reg <= '0;
        end
        if (cmd.scan)
        begin
            if (idx_reg < fill_reg)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (rdv_reg)
            begin
                for (int k = 0; k < NR; k++)
                begin
                    cnt_reg[k] <= cnt_reg[k] + CW'(match[k]);
                end
                if (bit_reg == fpm_pkg::TOP_BIT)
                begin
                    sum_reg <= sum_reg + SW'(rd_reg);
                end
            end
        end
        if (cmd.bitend)
        begin
            for (int k = 0; k < NR; k++)
            begin
                if (rank_reg[k] >= cnt_reg[k])
                begin
                    pfx_reg[k][bit_reg] <= 1'b1;
                    rank_reg[k]         <= rank_reg[k] - cnt_reg[k];
                end
                cnt_reg[k] <= '0;
            end
            idx_reg  <= '0;
            bit_reg  <= bit_reg - 5'd1;
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            dcnt_reg <= DCW'(SW - 1);
        end
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - DCW'(1);
            if (trial >= {1'b0, fill_reg})
            begin
                rem_reg <= trial - {1'b0, fill_reg};
                quo_reg <= {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SW-2:0], 1'b0};
            end
        end
    end

    assign last_us         = last_reg;
    assign average_us      = mean_reg;
    assign median_us       = p50_reg;
    assign pct95_us        = p95_reg;
    assign pct99_us        = p99_reg;
    assign peak_us         = peak_reg;
    assign window_fill     = 8'(fill_reg);
    assign frames_seen     = frames_reg;
    assign spikes_over_25  = spk_a_reg;
    assign spikes_over_33  = spk_b_reg;
    assign spikes_over_50  = spk_c_reg;
    assign stats_refreshed = refreshed_reg;

endmodule

FILE: tb/tb_fpm_if.sv
`timescale 1ns / 1ps

// Payload of one result as the checker sees it; the channel interfaces are shared with the RTL.
package tb_fpm_types;

    typedef struct packed {
        logic [23:0] last_us;
        logic [23:0] average_us;
        logic [23:0] median_us;
        logic [23:0] pct95_us;
        logic [23:0] pct99_us;
        logic [23:0] peak_us;
        logic [7:0]  window_fill;
        logic [31:0] frames_seen;
        logic [31:0] spikes_over_25;
        logic [31:0] spikes_over_33;
        logic [31:0] spikes_over_50;
        logic        stats_refreshed;
    } frame_report_t;

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = 128;
    localparam longint CYCLE_LIMIT = 64'd20000000;

    logic clk;
    logic rst_n;

    fpm_in_if  in_ch ();
    fpm_out_if out_ch ();

    frame_time_percentile_monitor_core #(.WINDOW_DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predicted monitor state.
    logic [63:0] frame_start;
    logic [23:0] window_ring [DEPTH];
    int          slot;
    int          fill;
    logic [31:0] frame_count;
    logic [31:0] spike25, spike33, spike50;
    logic [23:0] mean_held, p50_held, p95_held, p99_held, peak_held;

    tb_fpm_types::frame_report_t expected_reports [$];
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  failed = 1'b0;
    longint cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Cycle limit guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int percentile_index(int n, int k);
        int idx;
        idx = ((n - 1) * k + 50) / 100;
        return (idx < n) ? idx : n - 1;
    endfunction

    // Recompute mean, peak and order statistics over the filled window.
    function automatic void recompute_window_stats();
        logic [23:0] sorted [$];
        longint total;
        total = 0;
        for (int i = 0; i < fill; i++)
        begin
            sorted.push_back(window_ring[i]);
            total += window_ring[i];
        end
        if (fill == 0)
            return;
        sorted.sort();
        mean_held = 24'(total / fill);
        p50_held  = sorted[percentile_index(fill, 50)];
        p95_held  = sorted[percentile_index(fill, 95)];
        p99_held  = sorted[percentile_index(fill, 99)];
        peak_held = sorted[fill - 1];
    endfunction

    // Update the predicted state for one item and, for an end item, queue the report it causes.
    function automatic void predict_frame(logic op, logic [63:0] stamp);
        logic [63:0] span;
        logic [23:0] elapsed;
        bit refresh;
        tb_fpm_types::frame_report_t rep;
        if (op == fpm_pkg::OP_BEGIN)
        begin
            frame_start = stamp;
            return;
        end
        if (stamp < frame_start)
            elapsed = '0;
        else
        begin
            span = stamp - frame_start;
            elapsed = (span > 64'(fpm_pkg::CLAMP_MAX_US)) ? fpm_pkg::CLAMP_MAX_US : span[23:0];
        end
        window_ring[slot] = elapsed;
        slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
        if (fill < DEPTH)
            fill++;
        frame_count = frame_count + 32'd1;
        if (elapsed > fpm_pkg::SPIKE_A_US) spike25 = spike25 + 32'd1;
        if (elapsed > fpm_pkg::SPIKE_B_US) spike33 = spike33 + 32'd1;
        if (elapsed > fpm_pkg::SPIKE_C_US) spike50 = spike50 + 32'd1;
        refresh = (frame_count <= fpm_pkg::WARMUP_FRAMES) || (frame_count % 32'd15 == 0);
        if (refresh)
            recompute_window_stats();
        rep.last_us         = elapsed;
        rep.average_us      = mean_held;
        rep.median_us       = p50_held;
        rep.pct95_us        = p95_held;
        rep.pct99_us        = p99_held;
        rep.peak_us         = peak_held;
        rep.window_fill     = 8'(fill);
        rep.frames_seen     = frame_count;
        rep.spikes_over_25  = spike25;
        rep.spikes_over_33  = spike33;
        rep.spikes_over_50  = spike50;
        rep.stats_refreshed = refresh;
        expected_reports.push_back(rep);
    endfunction

    // Send one item, idling at random before it is offered; valid stays up after acceptance
    // until the next item or an idle cycle replaces it.
    task automatic send_event(logic op, logic [63:0] stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.timestamp_us <= stamp;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_frame(op, stamp);
    endtask

    // Receiver stalls and result checking.
    always @(posedge clk)
    begin
        tb_fpm_types::frame_report_t got, want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.last_us, out_ch.average_us, out_ch.median_us,
                       out_ch.pct95_us, out_ch.pct99_us, out_ch.peak_us,
                       out_ch.window_fill, out_ch.frames_seen, out_ch.spikes_over_25,
                       out_ch.spikes_over_33, out_ch.spikes_over_50,
                       out_ch.stats_refreshed};
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected report %p", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: report mismatch expected %p actual %p",
                                 $time, want, got);
                        failed = 1'b1;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        else
        begin
            out_ch.ready <= 1'b0;
        end
    end

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // Directed extremes and special cases.
    task automatic test_directed();
        send_event(fpm_pkg::OP_END, 64'd0);
        send_event(fpm_pkg::OP_END, 64'd30000);
        send_event(fpm_pkg::OP_BEGIN, 64'd100);
        send_event(fpm_pkg::OP_BEGIN, 64'd1000);
        send_event(fpm_pkg::OP_END, 64'd500);
        send_event(fpm_pkg::OP_BEGIN, 64'd0);
        send_event(fpm_pkg::OP_END, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(fpm_pkg::OP_END, 64'd10000000);
        send_event(fpm_pkg::OP_END, 64'd10000001);
        send_event(fpm_pkg::OP_BEGIN, 64'hFFFF_FFFF_FFFF_0000);
        send_event(fpm_pkg::OP_END, 64'hFFFF_FFFF_FFFF_FFFF);
        send_event(fpm_pkg::OP_BEGIN, 64'd0);
        send_event(fpm_pkg::OP_END, 64'd25000);
        send_event(fpm_pkg::OP_END, 64'd25001);
        send_event(fpm_pkg::OP_END, 64'd33333);
        send_event(fpm_pkg::OP_END, 64'd33334);
        send_event(fpm_pkg::OP_END, 64'd50000);
        send_event(fpm_pkg::OP_END, 64'd50001);
        send_event(fpm_pkg::OP_BEGIN, 64'h5555_5555_5555_5555);
        send_event(fpm_pkg::OP_BEGIN, 64'hAAAA_AAAA_AAAA_AAAA);
        send_event(fpm_pkg::OP_END, 64'hAAAA_AAAA_AAAB_0000);
    endtask

    // Random frame; mostly well-formed begin and end pairs.
    task automatic random_frame();
        logic [63:0] base;
        logic [63:0] len;
        int pick;
        base = {$urandom(), $urandom()};
        pick = $urandom_range(99);
        if (pick < 60)
            len = $urandom_range(60000);
        else if (pick < 75)
            len = $urandom_range(10100000, 9900000);
        else if (pick < 85)
            len = {$urandom(), $urandom()};
        else
            len = $urandom_range(20000, 60000);
        if ($urandom_range(9) < 8)
            send_event(fpm_pkg::OP_BEGIN, base);
        if ($urandom_range(9) == 0)
            send_event(fpm_pkg::OP_END, {$urandom(), $urandom()});
        else
            send_event(fpm_pkg::OP_END, base + len);
    endtask

    task automatic test_random(int frames);
        for (int i = 0; i < frames; i++)
        begin
            random_frame();
            if (i == frames / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = fpm_pkg::OP_BEGIN;
        in_ch.timestamp_us = '0;
        frame_start = '0;
        slot = 0;
        fill = 0;
        frame_count = '0;
        spike25 = '0;
        spike33 = '0;
        spike50 = '0;
        {mean_held, p50_held, p95_held, p99_held, peak_held} = '0;
        send_idle_pct = 22;
        recv_idle_pct = 84;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(210);
        send_idle_pct = 84;
        recv_idle_pct = 22;
        test_random(210);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(210);

        wait_drained();
        repeat (4000) @(posedge clk);
        if (!failed && expected_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: frame_time_percentile_monitor_core.f
rtl/fpm_pkg.sv
rtl/fpm_if.sv
rtl/fpm_ctrl.sv
rtl/fpm_dp.sv
rtl/frame_time_percentile_monitor_core.sv
tb/tb_fpm_if.sv
tb/tb.sv
